// ===== rtl/dapf_pkg.sv =====
// shared types and constants for the destination address and port drop filter
package dapf_pkg;

  typedef enum logic [2:0] {
    CMD_LOOKUP    = 3'd0,
    CMD_WR_RULE   = 3'd1,
    CMD_WR_PORT   = 3'd2,
    CMD_SET_COUNT = 3'd3,
    CMD_CLEAR     = 3'd4
  } dapf_cmd_t;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RULE_RD,
    S_RULE_CHK,
    S_PORT_RD,
    S_PORT_CHK
  } dapf_state_t;

  typedef struct packed {
    logic rule_rd;
    logic port_rd;
  } dapf_rd_req_t;

  typedef struct packed {
    logic rule_wr;
    logic port_wr;
  } dapf_wr_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic hit;
  } dapf_seq_status_t;

endpackage

// ===== rtl/dapf_tables.sv =====
// rule entry memory and port list memory, one write and one registered read each
module dapf_tables #(
  parameter int MAX_RULES = 16,
  parameter int MAX_PORTS = 8,
  localparam int RIW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1,
  localparam int PIW = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1,
  localparam int CW  = $clog2(MAX_PORTS + 1)
) (
  input  logic                 clk,
  input  dapf_pkg::dapf_wr_req_t wr_req,
  input  logic [RIW:0]         rule_wr_idx,
  input  logic [31:0]          rule_wr_addr,
  input  logic [CW-1:0]        rule_wr_cnt,
  input  logic [RIW+PIW:0]     port_wr_idx,
  input  logic [15:0]          port_wr_data,
  input  dapf_pkg::dapf_rd_req_t rd_req,
  input  logic [RIW:0]         rule_rd_idx,
  input  logic [RIW+PIW:0]     port_rd_idx,
  output logic [31:0]          rule_addr_q,
  output logic [CW-1:0]        rule_cnt_q,
  output logic [15:0]          port_q
);

  localparam int RULE_DEPTH = 2 << RIW;
  localparam int PORT_DEPTH = 2 << (RIW + PIW);

  logic [31:0]   rule_addr_mem [RULE_DEPTH];
  logic [CW-1:0] rule_cnt_mem  [RULE_DEPTH];
  logic [15:0]   port_mem      [PORT_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_req.rule_wr) begin
      rule_addr_mem[rule_wr_idx] <= rule_wr_addr;
      rule_cnt_mem[rule_wr_idx]  <= rule_wr_cnt;
    end
    if (rd_req.rule_rd) begin
      rule_addr_q <= rule_addr_mem[rule_rd_idx];
      rule_cnt_q  <= rule_cnt_mem[rule_rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_req.port_wr) begin
      port_mem[port_wr_idx] <= port_wr_data;
    end
    if (rd_req.port_rd) begin
      port_q <= port_mem[port_rd_idx];
    end
  end

endmodule

// ===== rtl/dapf_match_seq.sv =====
// lookup sequencer walking rules and ports through one shared equality comparator
module dapf_match_seq #(
  parameter int MAX_RULES = 16,
  parameter int MAX_PORTS = 8,
  localparam int RIW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1,
  localparam int PIW = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1,
  localparam int CW  = $clog2(MAX_PORTS + 1),
  localparam int RCW = $clog2(MAX_RULES + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic                     start_tbl,
  input  logic [RCW-1:0]           start_lim,
  input  logic [31:0]              start_addr,
  input  logic [15:0]              start_port,
  input  logic [31:0]              rule_addr_q,
  input  logic [CW-1:0]            rule_cnt_q,
  input  logic [15:0]              port_q,
  output dapf_pkg::dapf_rd_req_t   rd_req,
  output logic [RIW:0]             rule_rd_idx,
  output logic [RIW+PIW:0]         port_rd_idx,
  output dapf_pkg::dapf_seq_status_t status
);

  dapf_pkg::dapf_state_t state, state_next;

  logic           tbl;
  logic [RCW-1:0] rule_lim;
  logic [31:0]    key_addr;
  logic [15:0]    key_port;
  logic [RIW-1:0] rule_ptr;
  logic [PIW-1:0] port_ptr;

  logic [31:0] cmp_a, cmp_b;
  logic        cmp_eq;
  logic        more_rules, more_ports, no_ports;

  // shared comparator
  always_comb begin
    if (state == dapf_pkg::S_PORT_CHK) begin
      cmp_a = {16'd0, port_q};
      cmp_b = {16'd0, key_port};
    end else begin
      cmp_a = rule_addr_q;
      cmp_b = key_addr;
    end
  end
  assign cmp_eq = (cmp_a == cmp_b);

  assign more_rules = (32'(rule_ptr) + 32'd1) < 32'(rule_lim);
  assign more_ports = (32'(port_ptr) + 32'd1) < 32'(rule_cnt_q);
  assign no_ports   = (rule_cnt_q == '0);

  always_comb begin
    state_next = state;
    case (state)
      dapf_pkg::S_IDLE: begin
        if (start) state_next = dapf_pkg::S_RULE_RD;
      end
      dapf_pkg::S_RULE_RD: state_next = dapf_pkg::S_RULE_CHK;
      dapf_pkg::S_RULE_CHK: begin
        if (cmp_eq) begin
          state_next = no_ports ? dapf_pkg::S_IDLE : dapf_pkg::S_PORT_RD;
        end else begin
          state_next = more_rules ? dapf_pkg::S_RULE_RD : dapf_pkg::S_IDLE;
        end
      end
      dapf_pkg::S_PORT_RD: state_next = dapf_pkg::S_PORT_CHK;
      dapf_pkg::S_PORT_CHK: begin
        if (cmp_eq) begin
          state_next = dapf_pkg::S_IDLE;
        end else if (more_ports) begin
          state_next = dapf_pkg::S_PORT_RD;
        end else if (more_rules) begin
          state_next = dapf_pkg::S_RULE_RD;
        end else begin
          state_next = dapf_pkg::S_IDLE;
        end
      end
      default: state_next = dapf_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    rd_req.rule_rd = (state == dapf_pkg::S_RULE_RD);
    rd_req.port_rd = (state == dapf_pkg::S_PORT_RD);
    status.busy    = (state != dapf_pkg::S_IDLE);
    status.done    = 1'b0;
    status.hit     = 1'b0;
    case (state)
      dapf_pkg::S_RULE_CHK: begin
        status.done = (cmp_eq && no_ports) || (!cmp_eq && !more_rules);
        status.hit  = cmp_eq && no_ports;
      end
      dapf_pkg::S_PORT_CHK: begin
        status.done = cmp_eq || (!more_ports && !more_rules);
        status.hit  = cmp_eq;
      end
      default: begin
        status.done = 1'b0;
        status.hit  = 1'b0;
      end
    endcase
  end

  assign rule_rd_idx = {tbl, rule_ptr};
  assign port_rd_idx = {tbl, rule_ptr, port_ptr};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dapf_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      dapf_pkg::S_IDLE: begin
        if (start) begin
          tbl      <= start_tbl;
          rule_lim <= start_lim;
          key_addr <= start_addr;
          key_port <= start_port;
          rule_ptr <= '0;
        end
      end
      dapf_pkg::S_RULE_CHK: begin
        port_ptr <= '0;
        if (!cmp_eq) rule_ptr <= rule_ptr + 1'b1;
      end
      dapf_pkg::S_PORT_CHK: begin
        if (!cmp_eq) begin
          if (more_ports) begin
            port_ptr <= port_ptr + 1'b1;
          end else begin
            rule_ptr <= rule_ptr + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/dest_addr_port_drop_filter_unit.sv =====
// top level of the destination address and port drop filter
//
// input channel in_valid/in_ready carries one command word per handshake:
// a lookup of protocol, dest_addr and dest_port, or a table write
// (rule address and port count, one port, rule count, clear of both counts).
// output channel out_valid/out_ready returns one word per command: drop,
// 1 when an active rule of the TCP or UDP table matches the lookup.
// cfg_wr_en/cfg_wr_data write filter_enable; with it low all lookups answer 0.
// writes and lookups that need no table walk answer in the cycle after accept.
// a table walk reads one rule entry or one port at a time, each read state
// followed by a check state, through one registered read port per memory
// and one shared comparator.
// one word is in flight at a time; in_ready is low during a walk and while
// a result waits that the receiver does not take.
// reset clears filter_enable, both rule counts and out_valid;
// rule and port entries hold nothing useful until written.
module dest_addr_port_drop_filter_unit #(
  parameter int MAX_RULES = 16,
  parameter int MAX_PORTS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  command,
  input  logic [7:0]  protocol,
  input  logic [31:0] dest_addr,
  input  logic [15:0] dest_port,
  input  logic        table_select,
  input  logic [3:0]  rule_index,
  input  logic [31:0] rule_addr,
  input  logic [3:0]  port_count,
  input  logic [2:0]  port_slot,
  input  logic [15:0] rule_port,
  input  logic [4:0]  rule_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        drop
);

  localparam int RIW = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;
  localparam int PIW = (MAX_PORTS > 1) ? $clog2(MAX_PORTS) : 1;
  localparam int CW  = $clog2(MAX_PORTS + 1);
  localparam int RCW = $clog2(MAX_RULES + 1);

  logic           filter_enable;
  logic [RCW-1:0] rule_counts [2];

  logic accept;
  logic is_tcp, is_udp, lookup_tbl, idx_ok, slot_ok, go;
  logic [RCW-1:0] lookup_lim;

  dapf_pkg::dapf_wr_req_t     wr_req;
  dapf_pkg::dapf_rd_req_t     rd_req;
  dapf_pkg::dapf_seq_status_t seq_status;

  logic [RIW:0]     rule_wr_idx, rule_rd_idx;
  logic [RIW+PIW:0] port_wr_idx, port_rd_idx;
  logic [CW-1:0]    rule_wr_cnt, rule_cnt_q;
  logic [31:0]      rule_addr_q;
  logic [15:0]      port_q;
  logic [RCW-1:0]   count_sat;

  logic out_valid_next, drop_next;

  assign accept = in_valid && in_ready;
  assign in_ready = !seq_status.busy && (!out_valid || out_ready);

  assign is_tcp     = (protocol == dapf_pkg::PROTO_TCP);
  assign is_udp     = (protocol == dapf_pkg::PROTO_UDP);
  assign lookup_tbl = is_udp;
  assign lookup_lim = rule_counts[lookup_tbl];
  assign go = accept && (command == dapf_pkg::CMD_LOOKUP) && filter_enable &&
              (is_tcp || is_udp) && (lookup_lim != '0);

  assign idx_ok  = 32'(rule_index) < 32'(MAX_RULES);
  assign slot_ok = 32'(port_slot) < 32'(MAX_PORTS);

  assign rule_wr_idx = {table_select, RIW'(rule_index)};
  assign port_wr_idx = {table_select, RIW'(rule_index), PIW'(port_slot)};
  assign rule_wr_cnt = (32'(port_count) > 32'(MAX_PORTS)) ? CW'(MAX_PORTS) : CW'(port_count);
  assign count_sat   = (32'(rule_count) > 32'(MAX_RULES)) ? RCW'(MAX_RULES) : RCW'(rule_count);

  assign wr_req.rule_wr = accept && (command == dapf_pkg::CMD_WR_RULE) && idx_ok;
  assign wr_req.port_wr = accept && (command == dapf_pkg::CMD_WR_PORT) && idx_ok && slot_ok;

  dapf_tables #(
    .MAX_RULES (MAX_RULES),
    .MAX_PORTS (MAX_PORTS)
  ) u_tables (
    .clk          (clk),
    .wr_req       (wr_req),
    .rule_wr_idx  (rule_wr_idx),
    .rule_wr_addr (rule_addr),
    .rule_wr_cnt  (rule_wr_cnt),
    .port_wr_idx  (port_wr_idx),
    .port_wr_data (rule_port),
    .rd_req       (rd_req),
    .rule_rd_idx  (rule_rd_idx),
    .port_rd_idx  (port_rd_idx),
    .rule_addr_q  (rule_addr_q),
    .rule_cnt_q   (rule_cnt_q),
    .port_q       (port_q)
  );

  dapf_match_seq #(
    .MAX_RULES (MAX_RULES),
    .MAX_PORTS (MAX_PORTS)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (go),
    .start_tbl   (lookup_tbl),
    .start_lim   (lookup_lim),
    .start_addr  (dest_addr),
    .start_port  (dest_port),
    .rule_addr_q (rule_addr_q),
    .rule_cnt_q  (rule_cnt_q),
    .port_q      (port_q),
    .rd_req      (rd_req),
    .rule_rd_idx (rule_rd_idx),
    .port_rd_idx (port_rd_idx),
    .status      (seq_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_enable  <= 1'b0;
      rule_counts[0] <= '0;
      rule_counts[1] <= '0;
    end else begin
      if (cfg_wr_en) filter_enable <= cfg_wr_data;
      if (accept) begin
        case (command)
          dapf_pkg::CMD_SET_COUNT: rule_counts[table_select] <= count_sat;
          dapf_pkg::CMD_CLEAR: begin
            rule_counts[0] <= '0;
            rule_counts[1] <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    drop_next      = drop;
    if (seq_status.done) begin
      out_valid_next = 1'b1;
      drop_next      = seq_status.hit;
    end else if (accept && !go) begin
      out_valid_next = 1'b1;
      drop_next      = 1'b0;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    drop <= drop_next;
  end

`ifndef SYNTH
  a_no_accept_while_walking: assert property (@(posedge clk) disable iff (rst)
    seq_status.busy |-> !in_ready)
    else $error("input accepted during a table walk");

  a_done_into_free_slot: assert property (@(posedge clk) disable iff (rst)
    seq_status.done |-> !out_valid)
    else $error("walk finished while a result was still held");

  a_write_answers_zero: assert property (@(posedge clk) disable iff (rst)
    (accept && command != dapf_pkg::CMD_LOOKUP) |=> (out_valid && !drop))
    else $error("write command did not answer with drop low");

  a_lookup_disabled_zero: assert property (@(posedge clk) disable iff (rst)
    (accept && !filter_enable) |=> (out_valid && !drop))
    else $error("lookup with filtering off did not answer accept");
`endif

endmodule
